>>> src/xmpr_pkg.sv
package xmpr_pkg;

    // Frame geometry
    localparam int DATA_BYTES  = 128;
    localparam int FRAME_BYTES = DATA_BYTES + 4;
    localparam int WORDS       = DATA_BYTES / 2;
    localparam int DIDX_W      = $clog2(DATA_BYTES);
    localparam int WIDX_W      = $clog2(WORDS);

    // Frame positions
    localparam logic [7:0] POS_PKT        = 8'd1;
    localparam logic [7:0] POS_DATA_FIRST = 8'd3;
    localparam logic [7:0] POS_CHECK      = 8'(FRAME_BYTES - 1);

    // Protocol bytes
    localparam logic [7:0] BYTE_SOH  = 8'd1;
    localparam logic [7:0] BYTE_EOT  = 8'd4;
    localparam logic [7:0] BYTE_ACK  = 8'd6;
    localparam logic [7:0] BYTE_NACK = 8'd21;

    // Input operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Register map
    localparam logic REG_RETRY_LIMIT = 1'b0;
    localparam logic REG_IMAGE_BYTES = 1'b1;

    // Register reset values and the retry counter maximum
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd10;
    localparam logic [19:0] IMAGE_BYTES_RESET = 20'h80000;
    localparam logic [7:0]  RETRY_MAX         = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_START,
        MODE_RUN,
        MODE_EOT
    } mode_t;

    typedef enum logic [1:0] {
        ST_IN,
        ST_RD,
        ST_LD
    } seq_t;

    // One result item, reply_valid in the lowest bit
    typedef struct packed {
        logic [1:0]  pad;
        logic        failed;
        logic        done_res;
        logic [15:0] write_data;
        logic [17:0] write_address;
        logic        write_valid;
        logic [7:0]  reply_byte;
        logic        reply_valid;
    } result_t;

    // Byte write into the frame store
    typedef struct packed {
        logic              en;
        logic [DIDX_W-1:0] index;
        logic [7:0]        data;
    } store_wr_t;

endpackage

>>> src/xmodem_packet_receiver_top.sv
// XMODEM checksum receiver: one serial byte per transaction.
// A NACK, abort EOT or final ACK reply is shown in the cycle after the byte is taken;
// the ACK of a good frame rides on its last flash word. One byte is taken per
// cycle while the output slot is free; after a good frame the 64 flash words
// leave one at a time (store read, then load); the input stalls until the last is loaded.
// Reset: asynchronous, active low; clears control state, the frame store is not cleared.
module xmodem_packet_receiver_top
    import xmpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] reply_valid, [8:1] reply_byte, [9] write_valid, [27:10] write_address,
    // [43:28] write_data, [44] done_res, [45] failed, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [7:0]  retry_limit_reg;
    logic [19:0] image_bytes_reg;

    seq_t        seq_reg, seq_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  fidx_reg, fidx_next;
    logic [7:0]  pnum_reg, pnum_next;
    logic [7:0]  sum_reg, sum_next;
    logic [19:0] addr_reg, addr_next;
    logic [7:0]  retry_reg, retry_next;
    logic [17:0] base_reg, base_next;
    logic [WIDX_W-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        out_last_reg, out_last_next;

    store_wr_t   st_wr;
    logic [15:0] st_rd_data;

    logic        out_free;
    logic        in_accept;
    logic [7:0]  rx;
    logic [7:0]  fidx_inc;
    logic [7:0]  want;
    logic [19:0] addr_adv;
    logic        frame_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RESET;
            image_bytes_reg <= IMAGE_BYTES_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_RETRY_LIMIT: retry_limit_reg <= pwdata[7:0];
                REG_IMAGE_BYTES: image_bytes_reg <= pwdata[19:0];
                default:         retry_limit_reg <= retry_limit_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IMAGE_BYTES) ? {12'd0, image_bytes_reg}
                                                  : {24'd0, retry_limit_reg};

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (seq_reg == ST_IN) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    assign fidx_inc = fidx_reg + 8'd1;
    assign want     = addr_reg[14:7] + 8'd1;
    assign addr_adv = addr_reg + 20'(DATA_BYTES);
    assign frame_ok = (pnum_reg == want) && (sum_reg == rx);

    // Frame store write
    always_comb
    begin
        st_wr.en    = in_accept && (s_axis_tuser[0] == OP_BYTE) && (mode_reg == MODE_RUN)
                      && (retry_reg < retry_limit_reg)
                      && (fidx_reg >= POS_DATA_FIRST) && (fidx_reg < POS_CHECK);
        st_wr.index = DIDX_W'(fidx_reg - POS_DATA_FIRST);
        st_wr.data  = rx;
    end

    xmpr_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (st_wr),
        .rd_addr (cnt_reg),
        .rd_data (st_rd_data)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        seq_next       = seq_reg;
        mode_next      = mode_reg;
        fidx_next      = fidx_reg;
        pnum_next      = pnum_reg;
        sum_next       = sum_reg;
        addr_next      = addr_reg;
        retry_next     = retry_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        case (seq_reg)
            ST_IN:
            begin
                if (in_accept)
                begin
                    out_next = '0;
                    if (s_axis_tuser[0] == OP_START)
                    begin
                        addr_next  = '0;
                        fidx_next  = '0;
                        retry_next = '0;
                        sum_next   = '0;
                        mode_next  = MODE_START;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_START:
                            begin
                                if (rx == BYTE_SOH)
                                begin
                                    mode_next = MODE_RUN;
                                    fidx_next = POS_PKT;
                                    sum_next  = '0;
                                end
                                else
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_EOT:
                            begin
                                if (rx == BYTE_EOT)
                                begin
                                    mode_next           = MODE_IDLE;
                                    out_valid_next      = 1'b1;
                                    out_next.reply_valid = 1'b1;
                                    out_next.reply_byte = BYTE_ACK;
                                    out_next.done_res   = 1'b1;
                                    out_last_next       = 1'b1;
                                end
                            end
                            MODE_RUN:
                            begin
                                if (retry_reg >= retry_limit_reg)
                                begin
                                    // Abort: the byte is dropped
                                    mode_next            = MODE_IDLE;
                                    out_valid_next       = 1'b1;
                                    out_next.reply_valid = 1'b1;
                                    out_next.reply_byte  = BYTE_EOT;
                                    out_next.failed      = 1'b1;
                                    out_last_next        = 1'b1;
                                end
                                else
                                begin
                                    if (fidx_reg == POS_PKT)
                                    begin
                                        pnum_next = rx;
                                    end
                                    if (st_wr.en)
                                    begin
                                        sum_next = sum_reg + rx;
                                    end
                                    fidx_next = fidx_inc;
                                    if (fidx_reg == POS_CHECK)
                                    begin
                                        fidx_next = '0;
                                        sum_next  = '0;
                                        if (frame_ok)
                                        begin
                                            // Start the word flush
                                            retry_next = '0;
                                            base_next  = addr_reg[18:1];
                                            addr_next  = addr_adv;
                                            cnt_next   = '0;
                                            seq_next   = ST_RD;
                                            if (addr_adv == image_bytes_reg)
                                            begin
                                                mode_next = MODE_EOT;
                                            end
                                        end
                                        else
                                        begin
                                            if (retry_reg != RETRY_MAX)
                                            begin
                                                retry_next = retry_reg + 8'd1;
                                            end
                                            out_valid_next       = 1'b1;
                                            out_next.reply_valid = 1'b1;
                                            out_next.reply_byte  = BYTE_NACK;
                                            out_last_next        = 1'b1;
                                            if (addr_reg == image_bytes_reg)
                                            begin
                                                mode_next = MODE_EOT;
                                            end
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
            end
            ST_RD:
            begin
                // Store read of word cnt_reg is under way
                seq_next = ST_LD;
            end
            ST_LD:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.write_valid   = 1'b1;
                    out_next.write_address = base_reg + 18'(cnt_reg);
                    out_next.write_data    = st_rd_data;
                    if (cnt_reg == WIDX_W'(WORDS - 1))
                    begin
                        out_next.reply_valid = 1'b1;
                        out_next.reply_byte  = BYTE_ACK;
                        out_last_next        = 1'b1;
                        seq_next             = ST_IN;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        cnt_next      = cnt_reg + WIDX_W'(1);
                        seq_next      = ST_RD;
                    end
                end
            end
            default:
            begin
                seq_next = ST_IN;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IN;
            mode_reg      <= MODE_IDLE;
            fidx_reg      <= '0;
            pnum_reg      <= '0;
            sum_reg       <= '0;
            addr_reg      <= '0;
            retry_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            mode_reg      <= mode_next;
            fidx_reg      <= fidx_next;
            pnum_reg      <= pnum_next;
            sum_reg       <= sum_next;
            addr_reg      <= addr_next;
            retry_reg     <= retry_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> src/xmpr_store.sv
module xmpr_store
    import xmpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic [WIDX_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [WORDS];
    logic [7:0]  even_reg;
    logic [15:0] rd_data_reg;

    // Hold the even byte until its odd partner arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_reg <= '0;
        end
        else if (wr.en && !wr.index[0])
        begin
            even_reg <= wr.data;
        end
    end

    // Write a whole word on the odd byte
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.index[0])
        begin
            mem[wr.index[DIDX_W-1:1]] <= {wr.data, even_reg};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/xmpr_checker.sv
module xmpr_checker
    import xmpr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The last flash word carries the ACK
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] && m_axis_tlast |->
            m_axis_tdata[0] && (m_axis_tdata[8:1] == BYTE_ACK))
        else $error("last flash word without ACK");

    // An abort sends EOT alone
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[45] |->
            m_axis_tlast && !m_axis_tdata[9] && (m_axis_tdata[8:1] == BYTE_EOT))
        else $error("abort result malformed");

    // No byte is taken in the middle of a flush
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during flush");

    // Done is only reported with an ACK
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[44] |->
            m_axis_tlast && (m_axis_tdata[8:1] == BYTE_ACK) && !m_axis_tdata[45])
        else $error("done without ACK");

endmodule

bind xmodem_packet_receiver_top xmpr_checker u_xmpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
